@@ src/echo_distance_change_detector_defines.svh @@
// assertion macros for the echo distance change detector
// used by the modules that carry concurrent checks; needs nothing else
`ifndef ECHO_DISTANCE_CHANGE_DETECTOR_DEFINES_SVH
`define ECHO_DISTANCE_CHANGE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/edc_pkg.sv @@
// shared types and constants for the echo distance change detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

    localparam int RING_DEPTH = 5;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int WIDTH_W = 20;
    localparam int DIST_W  = 15;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;

    // width * 17 / 1000 as one multiply by a scaled reciprocal
    localparam int                 SCALE_SHIFT = 35;
    localparam int                 MUL_W       = 30;
    localparam logic [MUL_W-1:0]   SCALE_MUL   = 30'd584115563;
    localparam int                 PROD_W      = WIDTH_W + MUL_W;

    // widths above this give more than the saturation distance
    localparam logic [WIDTH_W-1:0] SAT_WIDTH   = 20'd1000058;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 15'd17000;

    localparam logic [CFG_W-1:0]   MARGIN_RESET  = 16'd10;
    localparam logic [CFG_W-1:0]   HOLD_MS_RESET = 16'd1000;

    localparam logic [INDEX_W-1:0] REG_MARGIN  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_HOLD_MS = 2'd1;

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              action;
        logic [DIST_W-1:0] distance;
    } meas_t;

    typedef struct packed {
        logic [CFG_W-1:0] margin;
        logic [CFG_W-1:0] hold_ms;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/echo_distance_change_detector.sv @@
// the input, scale and result registers lie between the input transfer and the result
// throughput: one item per cycle while out_stall is low; the 20 x 30 bit scaling multiply sets the stage length
// reset clears the distance ring, write slot, hold counter and ready flag, sets stable,
// and loads margin 10 and hold 1000 ms; it takes effect at once, no clearing pass
// depends on edc_pkg, edc_scale and edc_ring
`timescale 1ns / 1ps
`default_nettype none

module echo_distance_change_detector
    import edc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [WIDTH_W-1:0] echo_width_us,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DIST_W-1:0]       distance_cm,
    output logic                    stable,
    output logic                    ready_res,
    output logic                    detect_event,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    cfg_t  cfg_reg;
    meas_t meas;
    logic  meas_stall;

    assign cfg_ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.margin  <= MARGIN_RESET;
            cfg_reg.hold_ms <= HOLD_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MARGIN:  cfg_reg.margin  <= cfg_data;
                REG_HOLD_MS: cfg_reg.hold_ms <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    edc_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .echo_width_us (echo_width_us),
        .meas          (meas),
        .meas_stall    (meas_stall)
    );

    edc_ring u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .meas         (meas),
        .meas_stall   (meas_stall),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance_cm  (distance_cm),
        .stable       (stable),
        .ready_res    (ready_res),
        .detect_event (detect_event)
    );

endmodule

`default_nettype wire

@@ src/edc_scale.sv @@
// input register and microsecond to centimetre scaling stage
// depends on edc_pkg
`timescale 1ns / 1ps
`default_nettype none

module edc_scale
    import edc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [WIDTH_W-1:0] echo_width_us,
    output meas_t                   meas,
    input  wire logic               meas_stall
);

    logic               in_valid_reg;
    logic               action_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               meas_valid_reg;
    logic               meas_action_reg;
    logic [DIST_W-1:0]  meas_dist_reg;
    logic [DIST_W-1:0]  dist_next;
    logic [PROD_W-1:0]  product;
    logic               in_ready;
    logic               meas_ready;

    assign meas_ready = !meas_valid_reg || !meas_stall;
    assign in_ready   = !in_valid_reg || meas_ready;
    assign in_stall   = !in_ready;

    assign product = PROD_W'(width_reg) * PROD_W'(SCALE_MUL);

    always_comb
    begin
        if (width_reg > SAT_WIDTH)
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = product[SCALE_SHIFT + DIST_W - 1 : SCALE_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            meas_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (meas_ready)
            begin
                meas_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= action;
            width_reg  <= echo_width_us;
        end
        if (meas_ready && in_valid_reg)
        begin
            meas_action_reg <= action_reg;
            meas_dist_reg   <= dist_next;
        end
    end

    assign meas.valid    = meas_valid_reg;
    assign meas.action   = meas_action_reg;
    assign meas.distance = meas_dist_reg;

endmodule

`default_nettype wire

@@ src/edc_ring.sv @@
// distance ring, stability check, ready flag hold and result register
// depends on edc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "echo_distance_change_detector_defines.svh"

module edc_ring
    import edc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire meas_t             meas,
    output logic                   meas_stall,
    input  wire cfg_t              cfg,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DIST_W-1:0]      distance_cm,
    output logic                   stable,
    output logic                   ready_res,
    output logic                   detect_event
);

    logic [DIST_W-1:0] ring_reg [RING_DEPTH];
    logic [DIST_W-1:0] ring_next [RING_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              stable_reg;
    logic              stable_next;
    logic              ready_reg;
    logic              ready_next;
    logic [CFG_W-1:0]  hold_reg;
    logic [CFG_W-1:0]  hold_next;
    logic [DIST_W-1:0] last_reg;
    logic [DIST_W-1:0] last_next;
    logic              detect_next;
    logic              agree;
    logic              out_valid_reg;
    logic              out_detect_reg;
    logic              out_ready;
    logic              advance;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign meas_stall = !out_ready;
    assign advance    = meas.valid && out_ready;

    always_comb
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            if (slot_reg == SLOT_W'(i))
            begin
                ring_next[i] = meas.distance;
            end
            else
            begin
                ring_next[i] = ring_reg[i];
            end
        end
    end

    // every slot from one up strictly inside slot zero plus or minus margin
    always_comb
    begin
        agree = 1'b1;
        for (int i = 1; i < RING_DEPTH; i++)
        begin
            if (!((17'(ring_next[i]) + 17'(cfg.margin) > 17'(ring_next[0])) &&
                  (17'(ring_next[i]) < 17'(ring_next[0]) + 17'(cfg.margin))))
            begin
                agree = 1'b0;
            end
        end
    end

    always_comb
    begin
        slot_next   = slot_reg;
        stable_next = stable_reg;
        ready_next  = ready_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;
        detect_next = 1'b0;
        case (meas.action)
            ACT_MEASURE:
            begin
                last_next = meas.distance;
                if (slot_reg == SLOT_W'(RING_DEPTH - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                if (agree)
                begin
                    stable_next = 1'b1;
                end
                else if (stable_reg)
                begin
                    stable_next = 1'b0;
                    detect_next = 1'b1;
                    ready_next  = 1'b1;
                    hold_next   = '0;
                end
            end
            ACT_TICK:
            begin
                if (ready_reg)
                begin
                    if (hold_reg >= cfg.hold_ms)
                    begin
                        ready_next = 1'b0;
                        hold_next  = '0;
                    end
                    else
                    begin
                        hold_next = hold_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                detect_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg       <= '0;
            stable_reg     <= 1'b1;
            ready_reg      <= 1'b0;
            hold_reg       <= '0;
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_detect_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= meas.valid;
            end
            if (advance)
            begin
                if (meas.action == ACT_MEASURE)
                begin
                    for (int i = 0; i < RING_DEPTH; i++)
                    begin
                        ring_reg[i] <= ring_next[i];
                    end
                end
                slot_reg       <= slot_next;
                stable_reg     <= stable_next;
                ready_reg      <= ready_next;
                hold_reg       <= hold_next;
                last_reg       <= last_next;
                out_detect_reg <= detect_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign distance_cm  = last_reg;
    assign stable       = stable_reg;
    assign ready_res    = ready_reg;
    assign detect_event = out_detect_reg;

    `EDC_ASSERT_IMP(a_detect_flags, clk, rst_n, out_valid_reg && out_detect_reg,
        ready_reg && !stable_reg, "detect without ready set and stable cleared")
    `EDC_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1,
        slot_reg <= SLOT_W'(RING_DEPTH - 1), "write slot out of ring")
    `EDC_ASSERT_IMP(a_hold_idle, clk, rst_n, !ready_reg,
        hold_reg == '0, "hold counter running while ready is clear")
    `EDC_ASSERT_NXT(a_state_hold, clk, rst_n, !advance,
        $stable(slot_reg) && $stable(ready_reg) && $stable(hold_reg),
        "state changed without a transfer")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for echo_distance_change_detector: directed and random measurement
// and tick transfers under random stalls, checked against a behavioral predictor
// depends on edc_pkg and the echo_distance_change_detector rtl

module tb_top;
    import edc_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int CM_NUM       = 17;
    localparam int US_DEN       = 1000;
    localparam int SAT_CM       = 17000;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 142;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic               action;
        logic [WIDTH_W-1:0] width;
    } echo_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              stable;
        logic              ready;
        logic              detect;
    } echo_result_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic               action        = ACT_MEASURE;
    logic [WIDTH_W-1:0] echo_width_us = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [DIST_W-1:0]  distance_cm;
    logic               stable;
    logic               ready_res;
    logic               detect_event;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index     = REG_MARGIN;
    logic [CFG_W-1:0]   cfg_data      = '0;

    echo_distance_change_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .echo_width_us (echo_width_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .distance_cm   (distance_cm),
        .stable        (stable),
        .ready_res     (ready_res),
        .detect_event  (detect_event),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [DIST_W-1:0] ring_cm [RING_DEPTH];
    int unsigned       next_slot;
    logic              is_stable;
    logic              is_ready;
    logic [CFG_W-1:0]  hold_ticks;
    logic [DIST_W-1:0] latest_cm;
    logic [CFG_W-1:0]  margin_cm;
    logic [CFG_W-1:0]  hold_limit;

    echo_item_t   pending_items[$];
    echo_result_t expected_results[$];

    int errors      = 0;
    int cycle_count = 0;
    bit in_taken    = 1'b0;
    bit calm        = 1'b0;
    int in_gap      = 0;
    int stall_left  = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic clear_detector();
        int i;
        for (i = 0; i < RING_DEPTH; i++)
            ring_cm[i] = '0;
        next_slot  = 0;
        is_stable  = 1'b1;
        is_ready   = 1'b0;
        hold_ticks = '0;
        latest_cm  = '0;
        margin_cm  = 16'd10;
        hold_limit = 16'd1000;
    endtask

    function automatic echo_result_t track_distance(echo_item_t item);
        echo_result_t res;
        int unsigned  cm;
        int           base;
        int           m;
        int           v;
        int           i;
        logic         agree;
        res.detect = 1'b0;
        if (item.action == ACT_MEASURE) begin
            cm = item.width;
            cm = cm * CM_NUM / US_DEN;
            if (cm > SAT_CM)
                cm = SAT_CM;
            latest_cm = cm[DIST_W-1:0];
            ring_cm[next_slot] = latest_cm;
            next_slot = (next_slot + 1) % RING_DEPTH;
            base  = ring_cm[0];
            m     = margin_cm;
            agree = 1'b1;
            for (i = 1; i < RING_DEPTH; i++) begin
                v = ring_cm[i];
                if (!(base - m < v && v < base + m))
                    agree = 1'b0;
            end
            if (agree) begin
                is_stable = 1'b1;
            end
            else if (is_stable) begin
                is_stable  = 1'b0;
                res.detect = 1'b1;
                is_ready   = 1'b1;
                hold_ticks = '0;
            end
        end
        else if (is_ready) begin
            if (hold_ticks >= hold_limit) begin
                is_ready   = 1'b0;
                hold_ticks = '0;
            end
            else begin
                hold_ticks = hold_ticks + 1'b1;
            end
        end
        res.distance = latest_cm;
        res.stable   = is_stable;
        res.ready    = is_ready;
        return res;
    endfunction

    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result check first, then the input transfer of the same edge
    always @(posedge clk) begin
        echo_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
        else if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result distance_cm %0d stable %0b",
                             $time, distance_cm, stable);
                    $display("%0t: unexpected result ready_res %0b detect_event %0b",
                             $time, ready_res, detect_event);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (distance_cm !== want.distance) begin
                        $display("%0t: distance_cm expected %0d actual %0d",
                                 $time, want.distance, distance_cm);
                        errors++;
                    end
                    if (stable !== want.stable) begin
                        $display("%0t: stable expected %0b actual %0b",
                                 $time, want.stable, stable);
                        errors++;
                    end
                    if (ready_res !== want.ready) begin
                        $display("%0t: ready_res expected %0b actual %0b",
                                 $time, want.ready, ready_res);
                        errors++;
                    end
                    if (detect_event !== want.detect) begin
                        $display("%0t: detect_event expected %0b actual %0b",
                                 $time, want.detect, detect_event);
                        errors++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
                expected_results.push_back(track_distance('{action, echo_width_us}));
        end
        else begin
            in_taken = 1'b0;
        end
    end

    // input driver and output stall
    always @(negedge clk) begin
        logic       next_valid;
        echo_item_t next_item;
        next_valid = in_valid;
        next_item  = '{action, echo_width_us};
        if ($urandom_range(0, 199) == 0)
            calm = !calm;
        if (!rst_n) begin
            next_valid = 1'b0;
        end
        else if (!in_valid || in_taken) begin
            if (in_taken)
                in_gap = draw_gap();
            if (in_gap > 0) begin
                in_gap--;
                next_valid = 1'b0;
            end
            else if (pending_items.size() > 0) begin
                next_item  = pending_items.pop_front();
                next_valid = 1'b1;
            end
            else begin
                next_valid = 1'b0;
            end
        end
        if (!next_valid && $urandom_range(0, 1))
            next_item = '{1'($urandom_range(0, 1)),
                          WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1))};
        in_valid      <= next_valid;
        action        <= next_item.action;
        echo_width_us <= next_item.width;
        if (rst_n && stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            stall_left = rst_n ? draw_gap() : 0;
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MARGIN)
            margin_cm = val;
        else if (idx == REG_HOLD_MS)
            hold_limit = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= CFG_W'($urandom_range(0, 65535));
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_item(input logic act, input logic [WIDTH_W-1:0] w);
        pending_items.push_back('{act, w});
    endtask

    function automatic logic [WIDTH_W-1:0] width_for_cm(int cm);
        if (cm < 0)
            cm = 0;
        if (cm > SAT_CM)
            cm = SAT_CM;
        return WIDTH_W'((cm * US_DEN + CM_NUM - 1) / CM_NUM);
    endfunction

    task automatic add_ticks(input int n);
        int k;
        for (k = 0; k < n; k++)
            add_item(ACT_TICK, WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1)));
    endtask

    task automatic add_random_phase(input int n_items);
        int added;
        int pick;
        int r;
        int base;
        int jit;
        int off;
        int reps;
        int k;
        int t;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // settle on one distance, then jump away
                r = $urandom_range(0, 9);
                if (r == 0)
                    base = $urandom_range(0, 20);
                else if (r == 1)
                    base = $urandom_range(SAT_CM - 20, SAT_CM);
                else
                    base = $urandom_range(0, SAT_CM);
                jit = (margin_cm == 0) ? 2 : (margin_cm - 1) / 2;
                if (jit > 300)
                    jit = 300;
                reps = $urandom_range(4, 9);
                for (k = 0; k < reps; k++) begin
                    off = $urandom_range(0, 2 * jit);
                    add_item(ACT_MEASURE, width_for_cm(base + off - jit));
                    added++;
                    if ($urandom_range(0, 3) == 0) begin
                        t = $urandom_range(1, 3);
                        add_ticks(t);
                        added += t;
                    end
                end
                reps = $urandom_range(1, 2);
                for (k = 0; k < reps; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        add_item(ACT_MEASURE,
                                 WIDTH_W'($urandom_range(SAT_WIDTH, (1 << WIDTH_W) - 1)));
                    else
                        add_item(ACT_MEASURE, width_for_cm($urandom_range(0, SAT_CM)));
                    added++;
                end
            end
            else if (pick < 80) begin
                t = (hold_limit <= 40) ? hold_limit + $urandom_range(1, 3)
                                       : $urandom_range(1, 20);
                add_ticks(t);
                added += t;
            end
            else begin
                add_item(1'($urandom_range(0, 1)),
                         WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1)));
                added++;
            end
        end
    endtask

    logic [CFG_W-1:0] margin_set [PHASES] =
        '{16'd0, 16'd1, 16'hFFFF, 16'd20, 16'd10, 16'd50, 16'd3, 16'd0};
    logic [CFG_W-1:0] hold_set [PHASES] =
        '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'd3, 16'd12, 16'd0, 16'd0};

    initial begin
        int p;
        clear_detector();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero width, saturation edges, tick while not ready, detect
        add_item(ACT_MEASURE, '0);
        add_ticks(1);
        add_item(ACT_MEASURE, '1);
        add_item(ACT_MEASURE, SAT_WIDTH);
        add_item(ACT_MEASURE, SAT_WIDTH + 1'b1);
        add_ticks(1);
        add_item(ACT_MEASURE, width_for_cm(SAT_CM));
        add_item(ACT_MEASURE, width_for_cm(SAT_CM));
        add_item(ACT_MEASURE, 20'd58);
        wait_idle();

        // short hold, writes to unused indexes are dropped
        write_reg(REG_SPARE_2, CFG_W'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_3, CFG_W'($urandom_range(0, 65535)));
        write_reg(REG_HOLD_MS, 16'd2);
        add_ticks(4);
        add_item(ACT_MEASURE, width_for_cm(3));
        add_item(ACT_MEASURE, width_for_cm(5));
        add_item(ACT_MEASURE, width_for_cm(0));
        add_item(ACT_MEASURE, width_for_cm(12));
        add_item(ACT_MEASURE, width_for_cm(4));
        add_item(ACT_MEASURE, width_for_cm(9000));
        add_ticks(4);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                margin_set[p] = CFG_W'($urandom_range(0, 1000));
                hold_set[p]   = CFG_W'($urandom_range(0, 30));
            end
            if (p % 2 == 0) begin
                write_reg(REG_MARGIN, margin_set[p]);
                write_reg(REG_HOLD_MS, hold_set[p]);
            end
            else begin
                write_reg(REG_HOLD_MS, hold_set[p]);
                write_reg(REG_MARGIN, margin_set[p]);
            end
            add_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
